/* design/lcdseq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and helpers for the character display write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int DELAY_WIDTH = 8;
  localparam int CMP_W = (DELAY_WIDTH > 8) ? DELAY_WIDTH : 8;
  localparam logic [DELAY_WIDTH-1:0] DELAY_MAX = '1;

  localparam int INIT_COUNT = 5;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DATA   = 2'd1,
    OP_CMD    = 2'd2,
    OP_CURSOR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_TICK   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_BUSY   = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  localparam logic [1:0] REG_POWER_UP  = 2'd0;
  localparam logic [1:0] REG_SETUP     = 2'd1;
  localparam logic [1:0] REG_PULSE     = 2'd2;
  localparam logic [1:0] REG_LONG_WAIT = 2'd3;

  typedef enum logic [7:0] {
    PH_POWER  = 8'b0000_0001,
    PH_IDLE   = 8'b0000_0010,
    PH_SETUP  = 8'b0000_0100,
    PH_HIGH   = 8'b0000_1000,
    PH_GAP    = 8'b0001_0000,
    PH_LOW    = 8'b0010_0000,
    PH_SETTLE = 8'b0100_0000,
    PH_LONG   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] power_up_ticks;
    logic [7:0] setup_ticks;
    logic [7:0] pulse_ticks;
    logic [7:0] long_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic [1:0] status;
  } result_t;

  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    unique case (step)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [DELAY_WIDTH-1:0] clamp_delay(input logic [7:0] v,
                                                         input logic at_least_one);
    logic [CMP_W-1:0] x;
    x = CMP_W'(v);
    if (at_least_one && (v == 8'd0)) x = CMP_W'(1);
    if (x > CMP_W'(DELAY_MAX)) x = CMP_W'(DELAY_MAX);
    return DELAY_WIDTH'(x);
  endfunction

endpackage

/* design/lcdseq_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lcdseq_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output lcdseq_pkg::cfg_t   cfg
);
  import lcdseq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_up_ticks  <= 8'd45;
      cfg.setup_ticks     <= 8'd1;
      cfg.pulse_ticks     <= 8'd1;
      cfg.long_wait_ticks <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_UP:  cfg.power_up_ticks  <= cfg_data;
        REG_SETUP:     cfg.setup_ticks     <= cfg_data;
        REG_PULSE:     cfg.pulse_ticks     <= cfg_data;
        REG_LONG_WAIT: cfg.long_wait_ticks <= cfg_data;
      endcase
    end
  end

endmodule

/* design/lcdseq_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_core
// Sequencer state and its combinational update for one transaction.
// ----------------------------------------------------------------------------
module lcdseq_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lcdseq_pkg::cfg_t    cfg,
  input  logic [1:0]          opcode,
  input  logic [7:0]          byte_value,
  input  logic [5:0]          column,
  input  logic                row,
  output lcdseq_pkg::result_t result
);
  import lcdseq_pkg::*;

  phase_t                 phase, phase_next;
  logic [DELAY_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0]             pending_byte, pending_byte_next;
  logic                   pending_is_data, pending_is_data_next;
  logic                   needs_long_wait, needs_long_wait_next;
  logic [2:0]             init_step, init_step_next;
  logic                   init_done, init_done_next;

  logic                   idle;
  logic [DELAY_WIDTH-1:0] limit;
  logic [DELAY_WIDTH-1:0] cnt_inc;
  logic                   timed_done;
  logic                   load_req;
  logic [7:0]             load_val;
  logic                   load_data;
  logic                   finish;
  logic [2:0]             step_inc;
  logic [1:0]             status;

  assign idle = init_done && (phase == PH_IDLE);
  assign cnt_inc = (tick_count == DELAY_MAX) ? tick_count : tick_count + 1'b1;
  assign step_inc = init_step + 3'd1;

  always_comb begin
    unique case (phase)
      PH_POWER: limit = clamp_delay(cfg.power_up_ticks, 1'b1);
      PH_SETUP: limit = clamp_delay(cfg.setup_ticks, 1'b1);
      PH_HIGH,
      PH_LOW:   limit = clamp_delay(cfg.pulse_ticks, 1'b1);
      PH_LONG:  limit = clamp_delay(cfg.long_wait_ticks, 1'b1);
      default:  limit = DELAY_WIDTH'(1);
    endcase
  end

  assign timed_done = (cnt_inc >= limit);

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    pending_byte_next    = pending_byte;
    pending_is_data_next = pending_is_data;
    needs_long_wait_next = needs_long_wait;
    init_step_next       = init_step;
    init_done_next       = init_done;
    load_req             = 1'b0;
    load_val             = 8'h00;
    load_data            = 1'b0;
    finish               = 1'b0;
    status               = ST_TICK;

    if (opcode == OP_TICK) begin
      status = ST_TICK;
      if (phase != PH_IDLE) tick_count_next = timed_done ? '0 : cnt_inc;
      unique case (phase)
        PH_POWER: begin
          if (timed_done) begin
            init_step_next = 3'd0;
            load_req       = 1'b1;
            load_val       = init_byte(3'd0);
          end
        end
        PH_SETUP:  if (timed_done) phase_next = PH_HIGH;
        PH_HIGH:   if (timed_done) phase_next = PH_GAP;
        PH_GAP:    if (timed_done) phase_next = PH_LOW;
        PH_LOW:    if (timed_done) phase_next = PH_SETTLE;
        PH_SETTLE: begin
          if (timed_done) begin
            if (needs_long_wait && (cfg.long_wait_ticks != 8'd0)) phase_next = PH_LONG;
            else finish = 1'b1;
          end
        end
        PH_LONG:   if (timed_done) finish = 1'b1;
        default: begin
        end
      endcase

      if (finish) begin
        tick_count_next = '0;
        if (!init_done) begin
          init_step_next = step_inc;
          if (step_inc >= 3'(INIT_COUNT)) begin
            init_done_next = 1'b1;
            phase_next     = PH_IDLE;
          end else begin
            load_req = 1'b1;
            load_val = init_byte(step_inc);
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
    end else if (!idle) begin
      status = ST_BUSY;
    end else begin
      status   = ST_ACCEPT;
      load_req = 1'b1;
      unique case (opcode)
        OP_DATA: begin
          load_val  = byte_value;
          load_data = 1'b1;
        end
        OP_CMD:  load_val = byte_value;
        default: load_val = 8'h80 | {2'b00, column} | {1'b0, row, 6'b00_0000};
      endcase
    end

    if (load_req) begin
      pending_byte_next    = load_val;
      pending_is_data_next = load_data;
      needs_long_wait_next = !load_data && (load_val >= 8'h01) && (load_val <= 8'h03);
      phase_next           = PH_SETUP;
      tick_count_next      = '0;
    end
  end

  always_comb begin
    result.reg_select  = pending_is_data_next;
    result.enable_pin  = (phase_next == PH_HIGH) || (phase_next == PH_LOW);
    result.data_nibble = ((phase_next == PH_SETUP) || (phase_next == PH_HIGH))
                         ? pending_byte_next[7:4] : pending_byte_next[3:0];
    result.busy_res    = !(init_done_next && (phase_next == PH_IDLE));
    result.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_POWER;
      tick_count      <= '0;
      pending_byte    <= 8'h00;
      pending_is_data <= 1'b0;
      needs_long_wait <= 1'b0;
      init_step       <= 3'd0;
      init_done       <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      pending_byte    <= pending_byte_next;
      pending_is_data <= pending_is_data_next;
      needs_long_wait <= needs_long_wait_next;
      init_step       <= init_step_next;
      init_done       <= init_done_next;
    end
  end

endmodule

/* design/char_lcd_nibble_write_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// 4-bit character display write sequencer with power-up init list.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle unless item_stall is raised. Each
// item is registered on entry, the sequencer state is updated from it
// combinationally, and the pin levels land in a result register that holds
// while the output side is stalled. Display time passes only through tick
// items; the power-up wait, setup, pulse and long-wait lengths are counted in
// ticks and set by the timing registers. Writes arriving while the init list
// or a byte transfer runs are answered as refused.
module char_lcd_nibble_write_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] byte_value,
  input  logic [5:0] column,
  input  logic       row,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       reg_select,
  output logic       enable_pin,
  output logic [3:0] data_nibble,
  output logic       busy_res,
  output logic [1:0] status
);
  import lcdseq_pkg::*;

  cfg_t       cfg;
  result_t    result;
  logic       item_q_valid;
  logic [1:0] opcode_q;
  logic [7:0] byte_value_q;
  logic [5:0] column_q;
  logic       row_q;
  logic       out_free;
  logic       step;

  assign out_free   = !result_valid || !result_stall;
  assign step       = item_q_valid && out_free;
  assign item_stall = item_q_valid && !out_free;

  lcdseq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdseq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cfg        (cfg),
    .opcode     (opcode_q),
    .byte_value (byte_value_q),
    .column     (column_q),
    .row        (row_q),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      opcode_q     <= opcode;
      byte_value_q <= byte_value;
      column_q     <= column;
      row_q        <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      reg_select  <= result.reg_select;
      enable_pin  <= result.enable_pin;
      data_nibble <= result.data_nibble;
      busy_res    <= result.busy_res;
      status      <= result.status;
    end
  end

endmodule

/* design/lcdseq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level checks on the write sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdseq_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic       enable_pin,
  input logic       busy_res,
  input logic [1:0] status
);
  import lcdseq_pkg::*;

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(busy_res))
    else $error("result changed while stalled");

  // the enable strobe only rises inside a transfer
  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && enable_pin |-> busy_res)
    else $error("enable high while not busy");

  // a refused or accepted write always reports busy afterwards
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((status == ST_BUSY) || (status == ST_ACCEPT)) |-> busy_res)
    else $error("write result without busy");

  // the unused status code never appears
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status != ST_NONE))
    else $error("unused status code");

  // the input side stalls only behind a stalled result
  a_item_stall: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with the output free");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_lcdseq_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .enable_pin   (enable_pin),
  .busy_res     (busy_res),
  .status       (status)
);

/* tb/sv/tb_char_lcd_nibble_write_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer
// Self-checking bench for the 4-bit character display write sequencer. A
// directed table covers the writes refused during power-up, the init list,
// field extremes, clear/home settle and cursor addressing. Random phases
// follow, with several timing settings and with idle and stall patterns on
// both channels. A local pin-level model predicts each result that the table
// does not fix, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer;
  import lcdseq_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_POWER_UP;
  logic [7:0] cfg_data = 8'd0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] opcode = OP_TICK;
  logic [7:0] byte_value = 8'd0;
  logic [5:0] column = 6'd0;
  logic       row = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       reg_select;
  logic       enable_pin;
  logic [3:0] data_nibble;
  logic       busy_res;
  logic [1:0] status;

  char_lcd_nibble_write_sequencer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .byte_value  (byte_value),
    .column      (column),
    .row         (row),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .reg_select  (reg_select),
    .enable_pin  (enable_pin),
    .data_nibble (data_nibble),
    .busy_res    (busy_res),
    .status      (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  localparam logic [7:0] BOOT_CMDS [5] = '{8'h02, 8'h28, 8'h0C, 8'h01, 8'h06};
  localparam int BOOT_ROWS = 5;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] b;
    logic [5:0] c;
    logic       r;
    logic       fixed_on;
    result_t    fixed;
    logic       drain;
  } stim_row_t;

  stim_row_t dir_rows [0:20] = '{
    '{OP_DATA,   8'hFF, 6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_BUSY},   1'b0},
    '{OP_CMD,    8'h00, 6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_BUSY},   1'b0},
    '{OP_CURSOR, 8'h00, 6'd63, 1'b1, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_BUSY},   1'b0},
    '{OP_TICK,   8'hFF, 6'd63, 1'b1, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_TICK},   1'b0},
    '{OP_TICK,   8'h00, 6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_TICK},   1'b0},
    '{OP_DATA,   8'h00, 6'd0,  1'b0, 1'b1, '{1'b1, 1'b0, 4'h0, 1'b1, ST_ACCEPT}, 1'b1},
    '{OP_DATA,   8'hFF, 6'd0,  1'b0, 1'b1, '{1'b1, 1'b0, 4'hF, 1'b1, ST_ACCEPT}, 1'b0},
    '{OP_CMD,    8'h12, 6'd0,  1'b0, 1'b1, '{1'b1, 1'b0, 4'hF, 1'b1, ST_BUSY},   1'b1},
    '{OP_CMD,    8'h01, 6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_ACCEPT}, 1'b1},
    '{OP_CMD,    8'h02, 6'd0,  1'b0, 1'b0, '0,                                 1'b1},
    '{OP_CMD,    8'h03, 6'd0,  1'b0, 1'b0, '0,                                 1'b1},
    '{OP_CMD,    8'h04, 6'd0,  1'b0, 1'b0, '0,                                 1'b1},
    '{OP_CMD,    8'h00, 6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, ST_ACCEPT}, 1'b1},
    '{OP_CURSOR, 8'h00, 6'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 4'h8, 1'b1, ST_ACCEPT}, 1'b1},
    '{OP_CURSOR, 8'h00, 6'd39, 1'b1, 1'b1, '{1'b0, 1'b0, 4'hE, 1'b1, ST_ACCEPT}, 1'b1},
    '{OP_CURSOR, 8'h00, 6'd63, 1'b0, 1'b1, '{1'b0, 1'b0, 4'hB, 1'b1, ST_ACCEPT}, 1'b1},
    '{OP_CURSOR, 8'h00, 6'd63, 1'b1, 1'b0, '0,                                 1'b0},
    '{OP_TICK,   8'h00, 6'd0,  1'b0, 1'b0, '0,                                 1'b0},
    '{OP_DATA,   8'h5A, 6'd0,  1'b0, 1'b0, '0,                                 1'b1},
    '{OP_DATA,   8'hA5, 6'd0,  1'b0, 1'b0, '0,                                 1'b1},
    '{OP_TICK,   8'h00, 6'd0,  1'b0, 1'b1, '{1'b1, 1'b0, 4'h5, 1'b0, ST_TICK},   1'b0}
  };

  // pin-level model state
  cfg_t                   timing = '{8'd45, 8'd1, 8'd1, 8'd2};
  phase_t                 seq_ph = PH_POWER;
  logic [DELAY_WIDTH-1:0] tick_cnt = '0;
  logic [7:0]             cur_byte = 8'd0;
  logic                   cur_is_data = 1'b0;
  logic                   cur_long = 1'b0;
  logic [2:0]             boot_idx = 3'd0;
  logic                   boot_done = 1'b0;

  result_t pin_levels_due [$];
  int      mismatch_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  function automatic logic seq_idle();
    return boot_done && (seq_ph == PH_IDLE);
  endfunction

  function automatic logic [7:0] min_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // count one tick of a timed phase, true when the phase ends
  function automatic logic tick_done(input logic [7:0] lim);
    if (lim > DELAY_MAX) lim = DELAY_MAX;
    if (tick_cnt < DELAY_MAX) tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_byte(input logic [7:0] b, input logic is_data);
    cur_byte = b;
    cur_is_data = is_data;
    cur_long = !is_data && (b >= 8'h01) && (b <= 8'h03);
    seq_ph = PH_SETUP;
    tick_cnt = '0;
  endfunction

  function automatic void byte_done();
    tick_cnt = '0;
    if (!boot_done) begin
      boot_idx = boot_idx + 3'd1;
      if (boot_idx >= INIT_COUNT) begin
        boot_done = 1'b1;
        seq_ph = PH_IDLE;
      end else begin
        start_byte(BOOT_CMDS[boot_idx], 1'b0);
      end
    end else begin
      seq_ph = PH_IDLE;
    end
  endfunction

  function automatic void advance_tick();
    case (seq_ph)
      PH_POWER: begin
        if (tick_done(min_one(timing.power_up_ticks))) begin
          boot_idx = 3'd0;
          start_byte(BOOT_CMDS[0], 1'b0);
        end
      end
      PH_SETUP: if (tick_done(min_one(timing.setup_ticks))) seq_ph = PH_HIGH;
      PH_HIGH:  if (tick_done(min_one(timing.pulse_ticks))) seq_ph = PH_GAP;
      PH_GAP:   if (tick_done(8'd1)) seq_ph = PH_LOW;
      PH_LOW:   if (tick_done(min_one(timing.pulse_ticks))) seq_ph = PH_SETTLE;
      PH_SETTLE: begin
        if (tick_done(8'd1)) begin
          if (cur_long && (timing.long_wait_ticks != 8'd0)) seq_ph = PH_LONG;
          else byte_done();
        end
      end
      PH_LONG:  if (tick_done(min_one(timing.long_wait_ticks))) byte_done();
      default: ;
    endcase
  endfunction

  function automatic result_t lcd_pins_after(input opcode_t op, input logic [7:0] b,
                                             input logic [5:0] c, input logic r);
    result_t    res;
    logic [1:0] st;
    if (op == OP_TICK) begin
      advance_tick();
      st = ST_TICK;
    end else if (!seq_idle()) begin
      st = ST_BUSY;
    end else begin
      case (op)
        OP_DATA: start_byte(b, 1'b1);
        OP_CMD:  start_byte(b, 1'b0);
        default: start_byte(8'h80 | {2'b00, c} | (r ? 8'h40 : 8'h00), 1'b0);
      endcase
      st = ST_ACCEPT;
    end
    res.reg_select  = cur_is_data;
    res.enable_pin  = (seq_ph == PH_HIGH) || (seq_ph == PH_LOW);
    res.data_nibble = ((seq_ph == PH_SETUP) || (seq_ph == PH_HIGH)) ? cur_byte[7:4]
                                                                    : cur_byte[3:0];
    res.busy_res    = !seq_idle();
    res.status      = st;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_pins
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pin_levels_due.size() == 0) begin
        flag_mismatch("result transaction with nothing expected");
      end else begin
        want = pin_levels_due.pop_front();
        compare_field("reg_select", 4'(reg_select), 4'(want.reg_select));
        compare_field("enable_pin", 4'(enable_pin), 4'(want.enable_pin));
        compare_field("data_nibble", data_nibble, want.data_nibble);
        compare_field("busy_res", 4'(busy_res), 4'(want.busy_res));
        compare_field("status", 4'(status), 4'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_item(input opcode_t op, input logic [7:0] b, input logic [5:0] c,
                           input logic r, input logic fixed_on, input result_t fixed);
    result_t want;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    byte_value <= b;
    column     <= c;
    row        <= r;
    do @(posedge clk); while (item_stall);
    want = lcd_pins_after(op, b, c, r);
    if (fixed_on) want = fixed;
    pin_levels_due.push_back(want);
  endtask

  task automatic drain_ticks();
    while (!seq_idle())
      send_item(OP_TICK, 8'($urandom), 6'($urandom), 1'($urandom), 1'b0, '0);
  endtask

  task automatic settle_all();
    item_valid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POWER_UP:  timing.power_up_ticks = val;
      REG_SETUP:     timing.setup_ticks = val;
      REG_PULSE:     timing.pulse_ticks = val;
      REG_LONG_WAIT: timing.long_wait_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [7:0] su, input logic [7:0] pw,
                            input logic [7:0] lw);
    write_reg(REG_SETUP, su);
    write_reg(REG_PULSE, pw);
    write_reg(REG_LONG_WAIT, lw);
  endtask

  // mostly well-formed: ticks while busy, writes once idle
  task automatic random_item();
    opcode_t    op;
    logic [7:0] b;
    logic [5:0] c;
    logic       r;
    int         pick;
    pick = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    c = 6'($urandom_range(0, 63));
    r = 1'($urandom_range(0, 1));
    if (!seq_idle()) begin
      op = (pick < 88) ? OP_TICK : opcode_t'($urandom_range(1, 3));
    end else if (pick < 12) begin
      op = OP_TICK;
    end else begin
      op = opcode_t'($urandom_range(1, 3));
      if (op == OP_CMD && $urandom_range(0, 3) == 0) b = 8'($urandom_range(1, 3));
      if (op == OP_CURSOR && $urandom_range(0, 3) != 0) c = 6'($urandom_range(0, 39));
    end
    send_item(op, b, c, r, 1'b0, '0);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) random_item();
    settle_all();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_POWER_UP, 8'd255);

    for (int i = 0; i < $size(dir_rows); i++) begin
      send_item(dir_rows[i].op, dir_rows[i].b, dir_rows[i].c, dir_rows[i].r,
                dir_rows[i].fixed_on, dir_rows[i].fixed);
      if (dir_rows[i].drain) drain_ticks();
      if (i == BOOT_ROWS - 1) begin
        // cut the power-up wait short, then let the init list run out
        settle_all();
        write_reg(REG_POWER_UP, 8'd2);
        drain_ticks();
      end
    end
    settle_all();

    set_timing(8'd0, 8'd0, 8'd0);
    run_phase(80, 0, 0);

    set_timing(8'd3, 8'd2, 8'd5);
    write_reg(REG_POWER_UP, 8'd0);
    run_phase(80, 80, 0);

    set_timing(8'd1, 8'd4, 8'd1);
    run_phase(80, 0, 80);

    set_timing(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
               8'($urandom_range(0, 6)));
    run_phase(80, 12, 12);

    if (mismatch_count == 0) begin
      $display("tb_char_lcd_nibble_write_sequencer: done, clean");
    end else begin
      $display("tb_char_lcd_nibble_write_sequencer: done, errors");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb_char_lcd_nibble_write_sequencer: done, errors");
    $finish;
  end

endmodule
